// File: hw/rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg - shared types and constants for the set associative cache
// Command and status words between controller and datapath, fixed constants.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int          BYTE_W    = 8;
    localparam int          DATA_W    = 32;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [2:0]  MAX_SIZE  = 3'd4;
    localparam logic [2:0]  MIN_SIZE  = 3'd1;
    localparam logic        OP_WRITE  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic chk;
        logic fill_start;
        logic mod_step;
        logic fill_rd;
        logic fill_wr;
        logic commit;
        logic seg_next;
        logic byte_wr;
        logic byte_cap;
        logic out_load;
        logic clr_en;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic is_write;
        logic crossed;
        logic seg;
        logic look_hit;
        logic fill_last;
        logic last_byte;
    } t_status;

endpackage

// File: hw/rtl/sac_ram.sv
// ----------------------------------------------------------------------------
// sac_ram - generic single port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;

endmodule

// File: hw/rtl/sac_ctrl.sv
// ----------------------------------------------------------------------------
// sac_ctrl - cache sequencer
// Clearing pass, lookups, line fills, byte loop and result hand-off.
// ----------------------------------------------------------------------------
module sac_ctrl
    import sac_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_CHK, S_MOD, S_FILL_RD, S_FILL_WR,
        S_COMMIT, S_BYTE, S_BYTE_CAP, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = (r_out_valid && i_ready) ? 1'b0 : r_out_valid;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: n_state = S_CHK;
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (!i_st.is_write && !i_st.look_hit) begin
                    o_cmd.fill_start = 1'b1;
                    n_state          = S_MOD;
                end else if (!i_st.seg && i_st.crossed) begin
                    o_cmd.seg_next = 1'b1;
                    n_state        = S_LOOK;
                end else begin
                    n_state = S_BYTE;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_state        = S_FILL_RD;
            end
            S_FILL_RD: begin
                o_cmd.fill_rd = 1'b1;
                n_state       = S_FILL_WR;
            end
            S_FILL_WR: begin
                o_cmd.fill_wr = 1'b1;
                n_state       = i_st.fill_last ? S_COMMIT : S_FILL_RD;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (!i_st.seg && i_st.crossed) begin
                    o_cmd.seg_next = 1'b1;
                    n_state        = S_LOOK;
                end else begin
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                if (i_st.is_write) begin
                    o_cmd.byte_wr = 1'b1;
                    if (i_st.last_byte) n_state = S_DONE;
                end else begin
                    n_state = S_BYTE_CAP;
                end
            end
            S_BYTE_CAP: begin
                o_cmd.byte_cap = 1'b1;
                n_state        = i_st.last_byte ? S_DONE : S_BYTE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// File: hw/rtl/sac_dpath.sv
// ----------------------------------------------------------------------------
// sac_dpath - cache datapath
// Backing memory, line data, tag and valid arrays, victim LFSR, item regs.
// ----------------------------------------------------------------------------
module sac_dpath
    import sac_pkg::*;
#(
    parameter int NUM_SETS   = 128,
    parameter int NUM_WAYS   = 8,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_st,
    input  logic                 i_operation,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [2:0]           i_size,
    input  logic [DATA_W-1:0]    i_write_data,
    output logic [DATA_W-1:0]    o_read_data,
    output logic                 o_first_hit,
    output logic                 o_crossed_line,
    output logic                 o_second_hit
);

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int LINE_W = ADDR_BITS - OFF_W;
    localparam int TAG_W  = LINE_W - SET_W;
    localparam int DA_W   = SET_W + WAY_W + OFF_W;
    // reciprocal of the way count, exact for any 16-bit LFSR value
    localparam int     RCP_L = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 0;
    localparam int     RCP_S = 16 + RCP_L;
    localparam longint RCP_M = ((longint'(1) << RCP_S) + longint'(NUM_WAYS) - 1)
                               / longint'(NUM_WAYS);

    // item registers
    logic                   r_op;
    logic [ADDR_BITS-1:0]   r_addr;
    logic [2:0]             r_size;
    logic [DATA_W-1:0]      r_wdata;
    logic [DATA_W-1:0]      r_rdata;
    logic [1:0]             r_k;
    logic                   r_crossed;
    logic                   r_seg;
    logic                   r_hit0, r_hit1;
    logic [WAY_W-1:0]       r_way0, r_way1;
    // lookup and fill
    logic [NUM_WAYS*TAG_W-1:0] r_tag_row;
    logic [NUM_WAYS-1:0]    r_val_row;
    logic                   r_inv_any;
    logic [WAY_W-1:0]       r_inv_way;
    logic [15:0]            r_lfsr;
    logic [WAY_W-1:0]       r_fill_way;
    logic [OFF_W-1:0]       r_fill_idx;
    logic [ADDR_BITS-1:0]   r_clr;

    logic [2:0]             size_c;
    logic [OFF_W:0]         end_pos;
    logic [LINE_W-1:0]      line0, line1, cur_line;
    logic [SET_W-1:0]       cur_set;
    logic [TAG_W-1:0]       cur_tag;
    logic [OFF_W:0]         pos;
    logic                   pos_seg;
    logic [ADDR_BITS-1:0]   byte_addr;
    logic [BYTE_W-1:0]      wbyte;
    logic                   lk_hit, lk_inv;
    logic [WAY_W-1:0]       lk_way, lk_inv_way;
    logic [32:0]            rcp_prod;
    logic [15:0]            rcp_quo;
    logic [15:0]            rcp_rem;
    logic [WAY_W-1:0]       rcp_way;
    logic [15:0]            lfsr_n;
    logic [NUM_WAYS*TAG_W-1:0] tag_wr;
    logic [NUM_WAYS-1:0]    val_wr;

    logic [BYTE_W-1:0]         mem_q, dat_q;
    logic [NUM_WAYS*TAG_W-1:0] tag_q;
    logic [NUM_WAYS-1:0]       val_q;
    logic [ADDR_BITS-1:0]      mem_a;
    logic [DA_W-1:0]           dat_a;
    logic [SET_W-1:0]          row_a;
    logic                      val_we;

    // input size clamp and line crossing
    always_comb begin
        if (i_size == 3'd0)         size_c = MIN_SIZE;
        else if (i_size > MAX_SIZE) size_c = MAX_SIZE;
        else                        size_c = i_size;
        end_pos = {1'b0, i_address[OFF_W-1:0]} + (OFF_W+1)'(size_c);
    end

    // address split
    assign line0    = r_addr[ADDR_BITS-1:OFF_W];
    assign line1    = line0 + 1'b1;
    assign cur_line = r_seg ? line1 : line0;
    assign cur_set  = cur_line[SET_W-1:0];
    assign cur_tag  = cur_line[LINE_W-1:SET_W];
    assign pos      = {1'b0, r_addr[OFF_W-1:0]} + (OFF_W+1)'(r_k);
    assign pos_seg  = pos[OFF_W];
    assign byte_addr = r_addr + ADDR_BITS'(r_k);
    assign wbyte    = r_wdata[BYTE_W*r_k +: BYTE_W];

    // tag compare and first invalid way
    always_comb begin
        lk_hit     = 1'b0;
        lk_way     = '0;
        lk_inv     = 1'b0;
        lk_inv_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (val_q[w] && tag_q[w*TAG_W +: TAG_W] == cur_tag) begin
                lk_hit = 1'b1;
                lk_way = WAY_W'(w);
            end
            if (!val_q[w]) begin
                lk_inv     = 1'b1;
                lk_inv_way = WAY_W'(w);
            end
        end
    end

    // victim LFSR and its remainder by the way count, by reciprocal multiply
    assign lfsr_n   = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};
    assign rcp_prod = 33'(r_lfsr) * 33'(RCP_M);
    assign rcp_quo  = 16'(rcp_prod >> RCP_S);
    assign rcp_rem  = r_lfsr - rcp_quo * 16'(NUM_WAYS);
    assign rcp_way  = rcp_rem[WAY_W-1:0];

    // tag and valid rows with the filled way updated
    always_comb begin
        tag_wr = r_tag_row;
        val_wr = r_val_row;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == r_fill_way) begin
                tag_wr[w*TAG_W +: TAG_W] = cur_tag;
                val_wr[w]                = 1'b1;
            end
        end
    end

    // memory address muxes
    always_comb begin
        if (i_cmd.clr_en)       mem_a = r_clr;
        else if (i_cmd.fill_rd) mem_a = {cur_line, r_fill_idx};
        else                    mem_a = byte_addr;
        if (i_cmd.fill_wr)      dat_a = {cur_set, r_fill_way, r_fill_idx};
        else if (pos_seg)       dat_a = {line1[SET_W-1:0], r_way1, pos[OFF_W-1:0]};
        else                    dat_a = {line0[SET_W-1:0], r_way0, pos[OFF_W-1:0]};
        row_a  = i_cmd.clr_en ? r_clr[SET_W-1:0] : cur_set;
        val_we = (i_cmd.clr_en && r_clr[ADDR_BITS-1:SET_W] == '0) || i_cmd.commit;
    end

    sac_ram #(.WIDTH(BYTE_W), .DEPTH(2**ADDR_BITS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_en || i_cmd.byte_wr),
        .i_addr  (mem_a),
        .i_wdata (i_cmd.clr_en ? '0 : wbyte),
        .o_rdata (mem_q)
    );

    sac_ram #(.WIDTH(BYTE_W), .DEPTH(2**DA_W)) u_data (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fill_wr || (i_cmd.byte_wr && (pos_seg ? r_hit1 : r_hit0))),
        .i_addr  (dat_a),
        .i_wdata (i_cmd.fill_wr ? mem_q : wbyte),
        .o_rdata (dat_q)
    );

    sac_ram #(.WIDTH(NUM_WAYS*TAG_W), .DEPTH(2**SET_W)) u_tag (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_addr  (row_a),
        .i_wdata (tag_wr),
        .o_rdata (tag_q)
    );

    sac_ram #(.WIDTH(NUM_WAYS), .DEPTH(2**SET_W)) u_valid (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_addr  (row_a),
        .i_wdata (i_cmd.clr_en ? '0 : val_wr),
        .o_rdata (val_q)
    );

    // control registers: clear sweep and LFSR
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_lfsr <= LFSR_SEED;
        end else begin
            if (i_cmd.clr_en)     r_clr  <= r_clr + 1'b1;
            if (i_cmd.fill_start) r_lfsr <= lfsr_n;
        end
    end

    // item datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op      <= i_operation;
            r_addr    <= i_address;
            r_size    <= size_c;
            r_wdata   <= i_write_data;
            r_rdata   <= '0;
            r_k       <= '0;
            r_seg     <= 1'b0;
            r_hit0    <= 1'b0;
            r_hit1    <= 1'b0;
            r_crossed <= end_pos > (OFF_W+1)'(LINE_BYTES);
        end
        if (i_cmd.seg_next) r_seg <= 1'b1;
        if (i_cmd.chk) begin
            r_tag_row <= tag_q;
            r_val_row <= val_q;
            r_inv_any <= lk_inv;
            r_inv_way <= lk_inv_way;
            if (lk_hit) begin
                if (r_seg) begin
                    r_hit1 <= 1'b1;
                    r_way1 <= lk_way;
                end else begin
                    r_hit0 <= 1'b1;
                    r_way0 <= lk_way;
                end
            end
        end
        if (i_cmd.fill_start) r_fill_idx <= '0;
        if (i_cmd.mod_step) r_fill_way <= r_inv_any ? r_inv_way : rcp_way;
        if (i_cmd.fill_wr) r_fill_idx <= r_fill_idx + 1'b1;
        if (i_cmd.commit) begin
            if (r_seg) r_way1 <= r_fill_way;
            else       r_way0 <= r_fill_way;
        end
        if (i_cmd.byte_wr) r_k <= r_k + 1'b1;
        if (i_cmd.byte_cap) begin
            r_rdata[BYTE_W*r_k +: BYTE_W] <= dat_q;
            r_k                           <= r_k + 1'b1;
        end
        if (i_cmd.out_load) begin
            o_read_data    <= r_rdata;
            o_first_hit    <= r_hit0;
            o_crossed_line <= r_crossed;
            o_second_hit   <= r_hit1;
        end
    end

    // status to controller
    always_comb begin
        o_st.clr_last  = &r_clr;
        o_st.is_write  = (r_op == OP_WRITE);
        o_st.crossed   = r_crossed;
        o_st.seg       = r_seg;
        o_st.look_hit  = lk_hit;
        o_st.fill_last = &r_fill_idx;
        o_st.last_byte = ({1'b0, r_k} == r_size - 1'b1);
    end

endmodule

// File: hw/rtl/set_associative_cache.sv
// ----------------------------------------------------------------------------
// set_associative_cache - write-through, read-allocate cache with memory
// Set associative cache that fills an invalid way first, else a random (LFSR)
// victim, over an internal byte-addressed backing memory.
//
//   channel  valid     ready     payload
//   input    i_valid   o_ready   i_operation i_address i_size i_write_data
//   output   o_valid   i_ready   o_read_data o_first_hit o_crossed_line
//                                o_second_hit
//
// One item at a time. Each line touched costs a lookup (S_LOOK, S_CHK);
// a written byte takes S_BYTE, a read byte S_BYTE and then S_BYTE_CAP.
// A read miss adds a fill per filled line (victim pick, line copy,
// tag commit), bounded by the single byte port of the memory.
// After reset a clearing pass over all 2**ADDR_BITS addresses zeroes the
// memory and valid bits; o_ready stays low until it ends.
// A stalled result is held in the output register while the next item runs.
// ----------------------------------------------------------------------------
module set_associative_cache
    import sac_pkg::*;
#(
    parameter int NUM_SETS   = 128,
    parameter int NUM_WAYS   = 8,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_operation,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [2:0]           i_size,
    input  logic [DATA_W-1:0]    i_write_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DATA_W-1:0]    o_read_data,
    output logic                 o_first_hit,
    output logic                 o_crossed_line,
    output logic                 o_second_hit
);

    t_cmd    cmd;
    t_status st;

    sac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    sac_dpath #(
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_size         (i_size),
        .i_write_data   (i_write_data),
        .o_read_data    (o_read_data),
        .o_first_hit    (o_first_hit),
        .o_crossed_line (o_crossed_line),
        .o_second_hit   (o_second_hit)
    );

`ifndef SYNTHESIS
    // second line can only hit when the access crossed
    a_second_needs_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_second_hit || o_crossed_line))
        else $error("second_hit without crossed_line");

    // an accepted item keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after accept");

    // a fill is never issued together with a byte write
    a_no_fill_during_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.fill_wr && cmd.byte_wr))
        else $error("fill and byte write in the same cycle");
`endif

endmodule
